FILE: rtl/core/crg_pkg.sv
// Shared types, command codes, seed defaults and generator step functions.
package crg_pkg;

    typedef logic [31:0] t_word;
    typedef logic [3:0]  t_cmd;
    typedef logic [2:0]  t_cfg_idx;

    // Command codes carried by each input item.
    localparam t_cmd CMD_MWC    = 4'd0;
    localparam t_cmd CMD_SHR3   = 4'd1;
    localparam t_cmd CMD_CONG   = 4'd2;
    localparam t_cmd CMD_FIB    = 4'd3;
    localparam t_cmd CMD_KISS   = 4'd4;
    localparam t_cmd CMD_LFIB4  = 4'd5;
    localparam t_cmd CMD_SWB    = 4'd6;
    localparam t_cmd CMD_RELOAD = 4'd7;
    localparam t_cmd CMD_RESEED = 4'd8;

    // Seed register indexes; the hash unit emits its seeds in the same order.
    localparam int       CFG_COUNT       = 6;
    localparam t_cfg_idx CFG_MWC_HIGH    = 3'd0;
    localparam t_cfg_idx CFG_MWC_LOW     = 3'd1;
    localparam t_cfg_idx CFG_XORSHIFT    = 3'd2;
    localparam t_cfg_idx CFG_CONG        = 3'd3;
    localparam t_cfg_idx CFG_FIB_FIRST   = 3'd4;
    localparam t_cfg_idx CFG_FIB_SECOND  = 3'd5;

    // Default seeds.
    localparam t_word SEED_MWC_HIGH   = 32'd362436069;
    localparam t_word SEED_MWC_LOW    = 32'd521288629;
    localparam t_word SEED_XORSHIFT   = 32'd123456789;
    localparam t_word SEED_CONG       = 32'd380116160;
    localparam t_word SEED_FIB_FIRST  = 32'd224466889;
    localparam t_word SEED_FIB_SECOND = 32'd7584631;

    // Lags into the table, relative to the advanced pointer.
    localparam int LFIB4_LAG_A = 58;
    localparam int LFIB4_LAG_B = 119;
    localparam int LFIB4_LAG_C = 178;
    localparam int SWB_LAG_MIN = 34;
    localparam int SWB_LAG_SUB = 19;

    // Hash unit status toward the controller.
    typedef struct packed {
        logic       valid;
        logic       last;
        t_cfg_idx   index;
    } t_mix_status;

    function automatic t_word mwc_high_next(input t_word x);
        return 32'(32'd36969 * {16'd0, x[15:0]}) + {16'd0, x[31:16]};
    endfunction

    function automatic t_word mwc_low_next(input t_word x);
        return 32'(32'd18000 * {16'd0, x[15:0]}) + {16'd0, x[31:16]};
    endfunction

    function automatic t_word shr3_next(input t_word x);
        t_word a;
        a = x ^ (x << 17);
        a = a ^ (a >> 13);
        a = a ^ (a << 5);
        return a;
    endfunction

    function automatic t_word cong_next(input t_word x);
        return 32'(32'd69069 * x) + 32'd1234567;
    endfunction

    // KISS output taken from the already advanced generator words.
    function automatic t_word kiss_of(input t_word mh, input t_word ml,
                                      input t_word cg, input t_word xs);
        return (({mh[15:0], 16'd0} + ml) ^ cg) + xs;
    endfunction

    // One of the six steps of the integer hash.
    function automatic t_word mix_step(input t_word a, input logic [2:0] step);
        t_word r;
        unique case (step)
            3'd0:    r = (a + 32'h7ed55d16) + (a << 12);
            3'd1:    r = (a ^ 32'hc761c23c) ^ (a >> 19);
            3'd2:    r = (a + 32'h165667b1) + (a << 5);
            3'd3:    r = (a + 32'hd3a2646c) ^ (a << 9);
            3'd4:    r = (a + 32'hfd7046c5) + (a << 3);
            3'd5:    r = (a ^ 32'hb55a4f09) ^ (a >> 16);
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/crg_lag_ram.sv
// Lag table memory: one write port and one registered read port.
module crg_lag_ram #(
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  crg_pkg::t_word             i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output crg_pkg::t_word             o_rdata
);

    crg_pkg::t_word mem [DEPTH];
    crg_pkg::t_word r_rdata;

    // Write and read; the read data appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/crg_mixer.sv
// Iterative integer hash: derives six chained seeds, one hash step per cycle.
module crg_mixer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  crg_pkg::t_word        i_word,
    output crg_pkg::t_mix_status  o_status,
    output crg_pkg::t_word        o_seed
);

    logic              r_busy, n_busy;
    crg_pkg::t_word    r_a, n_a;
    logic [2:0]        r_step, n_step;
    crg_pkg::t_cfg_idx r_idx, n_idx;
    logic              r_valid, n_valid;
    logic              r_last, n_last;
    crg_pkg::t_cfg_idx r_oidx, n_oidx;

    // Step sequencing: six steps make one seed, which feeds the next hash.
    always_comb begin
        n_busy  = r_busy;
        n_a     = r_a;
        n_step  = r_step;
        n_idx   = r_idx;
        n_valid = 1'b0;
        n_last  = r_last;
        n_oidx  = r_oidx;
        if (i_start) begin
            n_busy = 1'b1;
            n_a    = i_word;
            n_step = 3'd0;
            n_idx  = 3'd0;
        end else if (r_busy) begin
            n_a = crg_pkg::mix_step(r_a, r_step);
            if (r_step == 3'd5) begin
                n_step  = 3'd0;
                n_valid = 1'b1;
                n_oidx  = r_idx;
                n_last  = (r_idx == crg_pkg::CFG_FIB_SECOND);
                n_idx   = r_idx + 3'd1;
                if (r_idx == crg_pkg::CFG_FIB_SECOND) begin
                    n_busy = 1'b0;
                end
            end else begin
                n_step = r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_step  <= 3'd0;
            r_idx   <= 3'd0;
            r_oidx  <= 3'd0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_last  <= n_last;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_oidx  <= n_oidx;
        end
        r_a <= n_a;
    end

    // Status fields in declaration order: valid, last, index.
    assign o_status = {r_valid, r_last, r_oidx};
    assign o_seed   = r_a;

endmodule

FILE: rtl/core/combined_random_generator_bank.sv
// Scalar commands (MWC, SHR3, CONG, FIB, KISS) step on accept; LFIB4 and SWB
// first read their lags one at a time through the single read port of the
// lag table. Reload and reseed refill the table, reseed after 36 hash steps;
// the refill writes one KISS value per cycle for 256 entries. After reset
// the block refills the table from the default seeds and stalls input
// meanwhile; configuration writes are taken at all times.
module combined_random_generator_bank #(
    parameter int LAG_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [3:0]           i_command,
    input  logic [31:0]          i_seed_word,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_random_value,
    // seed register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int AW = $clog2(LAG_DEPTH);
    localparam int FW = AW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LAG  = 3'd1;
    localparam logic [2:0] S_OUT  = 3'd2;
    localparam logic [2:0] S_MIX  = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;

    logic [2:0]           r_state, n_state;
    crg_pkg::t_cmd        r_cmd, n_cmd;
    crg_pkg::t_word       r_cfg [crg_pkg::CFG_COUNT];

    // Generator state.
    crg_pkg::t_word       r_mh, n_mh, r_ml, n_ml, r_xs, n_xs, r_cg, n_cg;
    crg_pkg::t_word       r_f1, n_f1, r_f2, n_f2;
    crg_pkg::t_word       r_smin, n_smin, r_ssub, n_ssub;
    logic                 r_borrow, n_borrow;
    logic [AW-1:0]        r_ptr, n_ptr;

    // Lag read sequencing.
    crg_pkg::t_word       r_acc, n_acc;
    logic [2:0]           r_rk, n_rk;
    logic                 r_dv;
    logic [1:0]           r_dk;
    logic [2:0]           rd_count;
    logic                 issue;
    int                   rd_offset;
    logic [FW-1:0]        r_fill, n_fill;

    // Output register.
    logic                 r_ov, n_ov;
    crg_pkg::t_word       r_out, n_out;

    logic                 in_accept;
    logic                 out_free;
    crg_pkg::t_word       res_value;
    crg_pkg::t_word       kiss_value;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    crg_pkg::t_word       ram_wdata, ram_rdata;

    logic                 mix_start;
    crg_pkg::t_mix_status mix_status;
    crg_pkg::t_word       mix_seed;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_ov || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign mix_start   = in_accept && (i_command == crg_pkg::CMD_RESEED);

    crg_lag_ram #(
        .DEPTH (LAG_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    crg_mixer u_mixer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mix_start),
        .i_word   (i_seed_word),
        .o_status (mix_status),
        .o_seed   (mix_seed)
    );

    // Seed registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[crg_pkg::CFG_MWC_HIGH]   <= crg_pkg::SEED_MWC_HIGH;
            r_cfg[crg_pkg::CFG_MWC_LOW]    <= crg_pkg::SEED_MWC_LOW;
            r_cfg[crg_pkg::CFG_XORSHIFT]   <= crg_pkg::SEED_XORSHIFT;
            r_cfg[crg_pkg::CFG_CONG]       <= crg_pkg::SEED_CONG;
            r_cfg[crg_pkg::CFG_FIB_FIRST]  <= crg_pkg::SEED_FIB_FIRST;
            r_cfg[crg_pkg::CFG_FIB_SECOND] <= crg_pkg::SEED_FIB_SECOND;
        end else if (i_cfg_valid && (i_cfg_index <= crg_pkg::CFG_FIB_SECOND)) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Table reads: four lags for LFIB4, two for SWB, one per cycle.
    always_comb begin
        rd_count = (r_cmd == crg_pkg::CMD_SWB) ? 3'd2 : 3'd4;
        if (r_cmd == crg_pkg::CMD_SWB) begin
            rd_offset = (r_rk[1:0] == 2'd0) ? crg_pkg::SWB_LAG_MIN : crg_pkg::SWB_LAG_SUB;
        end else begin
            unique case (r_rk[1:0])
                2'd0:    rd_offset = 0;
                2'd1:    rd_offset = crg_pkg::LFIB4_LAG_A;
                2'd2:    rd_offset = crg_pkg::LFIB4_LAG_B;
                default: rd_offset = crg_pkg::LFIB4_LAG_C;
            endcase
        end
        issue     = (r_state == S_LAG) && (r_rk < rd_count);
        ram_raddr = r_ptr + AW'(rd_offset);
    end

    // Result of the current command, taken from the advanced state.
    assign kiss_value = crg_pkg::kiss_of(r_mh, r_ml, r_cg, r_xs);

    always_comb begin
        unique case (r_cmd)
            crg_pkg::CMD_MWC:   res_value = {r_mh[15:0], 16'd0} + r_ml;
            crg_pkg::CMD_SHR3:  res_value = r_xs;
            crg_pkg::CMD_CONG:  res_value = r_cg;
            crg_pkg::CMD_FIB:   res_value = r_f1;
            crg_pkg::CMD_KISS:  res_value = kiss_value;
            crg_pkg::CMD_LFIB4: res_value = r_acc;
            crg_pkg::CMD_SWB:   res_value = r_smin - r_ssub;
            default:            res_value = '0;
        endcase
    end

    // Command sequencer.
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_mh     = r_mh;
        n_ml     = r_ml;
        n_xs     = r_xs;
        n_cg     = r_cg;
        n_f1     = r_f1;
        n_f2     = r_f2;
        n_smin   = r_smin;
        n_ssub   = r_ssub;
        n_borrow = r_borrow;
        n_ptr    = r_ptr;
        n_acc    = r_acc;
        n_rk     = r_rk;
        n_fill   = r_fill;
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = res_value;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd = i_command;
                    unique case (i_command)
                        crg_pkg::CMD_MWC: begin
                            n_mh    = crg_pkg::mwc_high_next(r_mh);
                            n_ml    = crg_pkg::mwc_low_next(r_ml);
                            n_state = S_OUT;
                        end
                        crg_pkg::CMD_SHR3: begin
                            n_xs    = crg_pkg::shr3_next(r_xs);
                            n_state = S_OUT;
                        end
                        crg_pkg::CMD_CONG: begin
                            n_cg    = crg_pkg::cong_next(r_cg);
                            n_state = S_OUT;
                        end
                        crg_pkg::CMD_FIB: begin
                            n_f1    = r_f2;
                            n_f2    = r_f1 + r_f2;
                            n_state = S_OUT;
                        end
                        crg_pkg::CMD_KISS: begin
                            n_mh    = crg_pkg::mwc_high_next(r_mh);
                            n_ml    = crg_pkg::mwc_low_next(r_ml);
                            n_cg    = crg_pkg::cong_next(r_cg);
                            n_xs    = crg_pkg::shr3_next(r_xs);
                            n_state = S_OUT;
                        end
                        crg_pkg::CMD_LFIB4: begin
                            n_ptr   = r_ptr + AW'(1);
                            n_acc   = '0;
                            n_rk    = 3'd0;
                            n_state = S_LAG;
                        end
                        crg_pkg::CMD_SWB: begin
                            n_ptr    = r_ptr + AW'(1);
                            n_borrow = (r_smin < r_ssub);
                            n_rk     = 3'd0;
                            n_state  = S_LAG;
                        end
                        crg_pkg::CMD_RELOAD: begin
                            n_mh    = r_cfg[crg_pkg::CFG_MWC_HIGH];
                            n_ml    = r_cfg[crg_pkg::CFG_MWC_LOW];
                            n_xs    = r_cfg[crg_pkg::CFG_XORSHIFT];
                            n_cg    = r_cfg[crg_pkg::CFG_CONG];
                            n_f1    = r_cfg[crg_pkg::CFG_FIB_FIRST];
                            n_f2    = r_cfg[crg_pkg::CFG_FIB_SECOND];
                            n_fill  = '0;
                            n_state = S_FILL;
                        end
                        crg_pkg::CMD_RESEED: begin
                            n_state = S_MIX;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_LAG: begin
                if (issue) begin
                    n_rk = r_rk + 3'd1;
                end
                if (r_dv) begin
                    if (r_cmd == crg_pkg::CMD_SWB) begin
                        if (r_dk == 2'd0) begin
                            n_smin = ram_rdata;
                        end else begin
                            n_ssub = ram_rdata + {31'd0, r_borrow};
                        end
                    end else begin
                        n_acc = r_acc + ram_rdata;
                    end
                    if ({1'b0, r_dk} == rd_count - 3'd1) begin
                        n_state = S_OUT;
                    end
                end
            end

            S_OUT: begin
                // Lag commands store their result at the advanced pointer.
                ram_we = (r_cmd == crg_pkg::CMD_LFIB4) || (r_cmd == crg_pkg::CMD_SWB);
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            S_MIX: begin
                if (mix_status.valid) begin
                    unique case (mix_status.index)
                        crg_pkg::CFG_MWC_HIGH:   n_mh = mix_seed;
                        crg_pkg::CFG_MWC_LOW:    n_ml = mix_seed;
                        crg_pkg::CFG_XORSHIFT:   n_xs = mix_seed;
                        crg_pkg::CFG_CONG:       n_cg = mix_seed;
                        crg_pkg::CFG_FIB_FIRST:  n_f1 = mix_seed;
                        crg_pkg::CFG_FIB_SECOND: n_f2 = mix_seed;
                        default:                 n_f2 = r_f2;
                    endcase
                    if (mix_status.last) begin
                        n_fill  = '0;
                        n_state = S_FILL;
                    end
                end
            end

            S_FILL: begin
                // Advance KISS while entries remain; write the previous value.
                if (!r_fill[AW]) begin
                    n_mh = crg_pkg::mwc_high_next(r_mh);
                    n_ml = crg_pkg::mwc_low_next(r_ml);
                    n_cg = crg_pkg::cong_next(r_cg);
                    n_xs = crg_pkg::shr3_next(r_xs);
                end
                if (r_fill != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_fill - FW'(1));
                    ram_wdata = kiss_value;
                end
                n_fill = r_fill + FW'(1);
                if (r_fill[AW]) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: loads in the result state once the slot is free.
    always_comb begin
        n_ov  = r_ov;
        n_out = r_out;
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
        if ((r_state == S_OUT) && out_free) begin
            n_ov  = 1'b1;
            n_out = res_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_cmd    <= crg_pkg::CMD_RELOAD;
            r_mh     <= crg_pkg::SEED_MWC_HIGH;
            r_ml     <= crg_pkg::SEED_MWC_LOW;
            r_xs     <= crg_pkg::SEED_XORSHIFT;
            r_cg     <= crg_pkg::SEED_CONG;
            r_f1     <= crg_pkg::SEED_FIB_FIRST;
            r_f2     <= crg_pkg::SEED_FIB_SECOND;
            r_smin   <= '0;
            r_ssub   <= '0;
            r_borrow <= 1'b0;
            r_ptr    <= '0;
            r_rk     <= 3'd0;
            r_dv     <= 1'b0;
            r_fill   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmd    <= n_cmd;
            r_mh     <= n_mh;
            r_ml     <= n_ml;
            r_xs     <= n_xs;
            r_cg     <= n_cg;
            r_f1     <= n_f1;
            r_f2     <= n_f2;
            r_smin   <= n_smin;
            r_ssub   <= n_ssub;
            r_borrow <= n_borrow;
            r_ptr    <= n_ptr;
            r_rk     <= n_rk;
            r_dv     <= issue;
            r_fill   <= n_fill;
            r_ov     <= n_ov;
        end
        r_acc <= n_acc;
        r_dk  <= r_rk[1:0];
        r_out <= n_out;
    end

    assign o_out_valid    = r_ov;
    assign o_random_value = r_out;

endmodule

FILE: sim/tb_combined_random_generator_bank.sv
// Self-checking testbench for the combined random generator bank.
`timescale 1ns / 1ps

module tb_combined_random_generator_bank;

    localparam int             HALF_PERIOD  = 6;
    localparam int             MAX_GAP      = 13;
    localparam int             DRAIN_CYCLES = 400;
    localparam int             STALL_LIMIT  = 4000;
    localparam int             PHASES       = 6;
    localparam int             LAG_PHASE    = 3;
    localparam int             TABLE_SIZE   = 256;
    localparam crg_pkg::t_word ALL_ONES     = 32'hFFFF_FFFF;

    // Commands that the block must ignore.
    localparam crg_pkg::t_cmd CMD_SPARE_FIRST = 4'd9;
    localparam crg_pkg::t_cmd CMD_SPARE_LAST  = 4'd15;

    localparam crg_pkg::t_word DEFAULT_SEEDS [crg_pkg::CFG_COUNT] = '{
        crg_pkg::SEED_MWC_HIGH, crg_pkg::SEED_MWC_LOW, crg_pkg::SEED_XORSHIFT,
        crg_pkg::SEED_CONG, crg_pkg::SEED_FIB_FIRST, crg_pkg::SEED_FIB_SECOND
    };

    // One directed item; typed rows carry a value known without computation.
    typedef struct packed {
        crg_pkg::t_cmd  cmd;
        crg_pkg::t_word word;
        logic           typed;
        crg_pkg::t_word value;
    } t_row;

    localparam int ROWS = 25;
    localparam t_row DIRECTED [ROWS] = '{
        '{crg_pkg::CMD_FIB,    32'd0,    1'b1, 32'd7584631},
        '{crg_pkg::CMD_FIB,    32'd0,    1'b1, 32'd232051520},
        '{crg_pkg::CMD_MWC,    32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_SHR3,   32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_CONG,   32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_KISS,   32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_LFIB4,  32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_SWB,    32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_SWB,    ALL_ONES, 1'b0, 32'd0},
        '{CMD_SPARE_FIRST,     ALL_ONES, 1'b0, 32'd0},
        '{CMD_SPARE_LAST,      32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_RELOAD, ALL_ONES, 1'b0, 32'd0},
        '{crg_pkg::CMD_MWC,    32'd0,    1'b1, 32'd0},
        '{crg_pkg::CMD_SHR3,   32'd0,    1'b1, 32'd0},
        '{crg_pkg::CMD_FIB,    32'd0,    1'b1, 32'd0},
        '{crg_pkg::CMD_CONG,   32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_KISS,   32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_LFIB4,  32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_SWB,    32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_RESEED, 32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_KISS,   32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_RESEED, ALL_ONES, 1'b0, 32'd0},
        '{crg_pkg::CMD_LFIB4,  32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_SWB,    32'd0,    1'b0, 32'd0},
        '{crg_pkg::CMD_FIB,    32'd0,    1'b0, 32'd0}
    };

    typedef struct {
        crg_pkg::t_cmd  cmd;
        crg_pkg::t_word value;
    } t_awaited;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [3:0]  i_command;
    logic [31:0] i_seed_word;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_random_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // Values still owed by the block, oldest first.
    t_awaited awaited_values[$];

    int unsigned errors        = 0;
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned seedings      = 0;
    int unsigned cfg_writes    = 0;
    int unsigned idle_count    = 0;
    bit          quiet_stretch = 1'b0;
    logic        moved;

    // Generator state of the bank as the testbench sees it.
    crg_pkg::t_word seed_cfg [crg_pkg::CFG_COUNT];
    crg_pkg::t_word mwc_hi, mwc_lo, xs_word, cg_word, fib_a, fib_b;
    crg_pkg::t_word swb_min, swb_sub;
    logic           swb_carry;
    logic [7:0]     lag_ptr;
    crg_pkg::t_word lag_tab [TABLE_SIZE];

    combined_random_generator_bank u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_seed_word    (i_seed_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_random_value (o_random_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Two 16-bit multiply-with-carry halves, combined into one word.
    function automatic crg_pkg::t_word step_mwc();
        mwc_hi = 32'd36969 * (mwc_hi & 32'h0000_FFFF) + (mwc_hi >> 16);
        mwc_lo = 32'd18000 * (mwc_lo & 32'h0000_FFFF) + (mwc_lo >> 16);
        return (mwc_hi << 16) + mwc_lo;
    endfunction

    function automatic crg_pkg::t_word step_shr3();
        xs_word = xs_word ^ (xs_word << 17);
        xs_word = xs_word ^ (xs_word >> 13);
        xs_word = xs_word ^ (xs_word << 5);
        return xs_word;
    endfunction

    function automatic crg_pkg::t_word step_cong();
        cg_word = 32'd69069 * cg_word + 32'd1234567;
        return cg_word;
    endfunction

    function automatic crg_pkg::t_word step_fib();
        crg_pkg::t_word sum;
        sum   = fib_a + fib_b;
        fib_a = fib_b;
        fib_b = sum;
        return fib_a;
    endfunction

    function automatic crg_pkg::t_word step_kiss();
        crg_pkg::t_word m, c, s;
        m = step_mwc();
        c = step_cong();
        s = step_shr3();
        return (m ^ c) + s;
    endfunction

    // Lagged sum over the table; all indexes wrap at 8 bits.
    function automatic crg_pkg::t_word step_lfib4();
        crg_pkg::t_word v;
        lag_ptr = lag_ptr + 8'd1;
        v = lag_tab[lag_ptr] + lag_tab[8'(lag_ptr + crg_pkg::LFIB4_LAG_A)]
            + lag_tab[8'(lag_ptr + crg_pkg::LFIB4_LAG_B)]
            + lag_tab[8'(lag_ptr + crg_pkg::LFIB4_LAG_C)];
        lag_tab[lag_ptr] = v;
        return v;
    endfunction

    // Subtract with borrow; the borrow comes from the previous pair.
    function automatic crg_pkg::t_word step_swb();
        crg_pkg::t_word v;
        lag_ptr   = lag_ptr + 8'd1;
        swb_carry = (swb_min < swb_sub);
        swb_min   = lag_tab[8'(lag_ptr + crg_pkg::SWB_LAG_MIN)];
        swb_sub   = lag_tab[8'(lag_ptr + crg_pkg::SWB_LAG_SUB)] + {31'd0, swb_carry};
        v         = swb_min - swb_sub;
        lag_tab[lag_ptr] = v;
        return v;
    endfunction

    // Seeds the generators and refills the whole table with KISS values.
    function automatic void refill_table(input crg_pkg::t_word s [crg_pkg::CFG_COUNT]);
        mwc_hi  = s[crg_pkg::CFG_MWC_HIGH];
        mwc_lo  = s[crg_pkg::CFG_MWC_LOW];
        xs_word = s[crg_pkg::CFG_XORSHIFT];
        cg_word = s[crg_pkg::CFG_CONG];
        fib_a   = s[crg_pkg::CFG_FIB_FIRST];
        fib_b   = s[crg_pkg::CFG_FIB_SECOND];
        for (int i = 0; i < TABLE_SIZE; i++) begin
            lag_tab[i] = step_kiss();
        end
        lag_ptr = 8'd0;
    endfunction

    function automatic crg_pkg::t_word scramble(input crg_pkg::t_word a);
        a = (a + 32'h7ed55d16) + (a << 12);
        a = (a ^ 32'hc761c23c) ^ (a >> 19);
        a = (a + 32'h165667b1) + (a << 5);
        a = (a + 32'hd3a2646c) ^ (a << 9);
        a = (a + 32'hfd7046c5) + (a << 3);
        a = (a ^ 32'hb55a4f09) ^ (a >> 16);
        return a;
    endfunction

    // Advances the bank by one command; returns 1 when a value comes out.
    function automatic bit bank_step(input crg_pkg::t_cmd cmd, input crg_pkg::t_word word,
                                     output crg_pkg::t_word value);
        crg_pkg::t_word derived [crg_pkg::CFG_COUNT];
        value = '0;
        case (cmd)
            crg_pkg::CMD_MWC:   value = step_mwc();
            crg_pkg::CMD_SHR3:  value = step_shr3();
            crg_pkg::CMD_CONG:  value = step_cong();
            crg_pkg::CMD_FIB:   value = step_fib();
            crg_pkg::CMD_KISS:  value = step_kiss();
            crg_pkg::CMD_LFIB4: value = step_lfib4();
            crg_pkg::CMD_SWB:   value = step_swb();
            crg_pkg::CMD_RELOAD: begin
                refill_table(seed_cfg);
                return 1'b0;
            end
            crg_pkg::CMD_RESEED: begin
                derived[0] = scramble(word);
                for (int i = 1; i < crg_pkg::CFG_COUNT; i++) begin
                    derived[i] = scramble(derived[i - 1]);
                end
                refill_table(derived);
                return 1'b0;
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic crg_pkg::t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input crg_pkg::t_word got,
                                   input crg_pkg::t_word want);
        $display("[%0t] MISMATCH %s: got %08h, want %08h", $time, what, got, want);
        errors++;
    endtask

    task automatic check_result();
        t_awaited head;
        results_seen++;
        if (awaited_values.size() == 0) begin
            report_mismatch("result with nothing awaited", o_random_value, '0);
        end else begin
            head = awaited_values.pop_front();
            if (o_random_value !== head.value) begin
                report_mismatch($sformatf("random_value after command %0d", head.cmd),
                                o_random_value, head.value);
            end
        end
    endtask

    task automatic write_seed(input crg_pkg::t_cfg_idx idx, input crg_pkg::t_word data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        seed_cfg[idx] = data;
        cfg_writes++;
    endtask

    // Phase 0 zeroes the seeds, 1 sets all ones, 2 the defaults, the rest random.
    task automatic load_phase_seeds(input int phase);
        crg_pkg::t_word v;
        for (int r = 0; r < crg_pkg::CFG_COUNT; r++) begin
            case (phase)
                0:       v = '0;
                1:       v = ALL_ONES;
                2:       v = DEFAULT_SEEDS[r];
                default: v = pick_word();
            endcase
            write_seed(crg_pkg::t_cfg_idx'(r), v);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Offers one item after a random gap and records what it should produce.
    task automatic send_item(input crg_pkg::t_cmd cmd, input crg_pkg::t_word word,
                             input bit typed, input crg_pkg::t_word typed_value);
        int unsigned    gap;
        crg_pkg::t_word predicted;
        gap = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_seed_word <= word;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_sent++;
        if (cmd == crg_pkg::CMD_RELOAD || cmd == crg_pkg::CMD_RESEED) begin
            seedings++;
        end
        if (bank_step(cmd, word, predicted)) begin
            awaited_values.push_back('{cmd, typed ? typed_value : predicted});
        end
    endtask

    // The lag phase has no seeding, so the pointer is sure to wrap.
    task automatic run_random(input int target, input bit lag_phase);
        int            made;
        int unsigned   roll;
        crg_pkg::t_cmd cmd;
        made = 0;
        while (made < target) begin
            if (made % 60 == 0) begin
                quiet_stretch = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                cmd = crg_pkg::t_cmd'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            end else if (lag_phase) begin
                cmd = (roll < 48) ? crg_pkg::CMD_LFIB4 :
                      (roll < 93) ? crg_pkg::CMD_SWB :
                      crg_pkg::t_cmd'($urandom_range(crg_pkg::CMD_MWC, crg_pkg::CMD_KISS));
            end else if (roll < 7) begin
                cmd = crg_pkg::CMD_RELOAD;
            end else if (roll < 11) begin
                cmd = crg_pkg::CMD_RESEED;
            end else begin
                cmd = crg_pkg::t_cmd'($urandom_range(crg_pkg::CMD_MWC, crg_pkg::CMD_SWB));
            end
            send_item(cmd, pick_word(), 1'b0, '0);
            if (cmd <= crg_pkg::CMD_RESEED) begin
                made++;
            end
        end
        quiet_stretch = 1'b0;
    endtask

    // Waits for every owed value, then for any refill still running.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus: reset, then per phase new seeds, directed rows once, random items.
    initial begin
        seed_cfg = DEFAULT_SEEDS;
        swb_min   = '0;
        swb_sub   = '0;
        swb_carry = 1'b0;
        refill_table(seed_cfg);

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_command   <= crg_pkg::CMD_MWC;
        i_seed_word <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= crg_pkg::CFG_MWC_HIGH;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                settle();
            end
            load_phase_seeds(p);
            if (p == 0) begin
                for (int r = 0; r < ROWS; r++) begin
                    send_item(DIRECTED[r].cmd, DIRECTED[r].word,
                              DIRECTED[r].typed, DIRECTED[r].value);
                end
            end
            run_random((p == LAG_PHASE) ? 320 : 155, p == LAG_PHASE);
        end
        settle();

        $display("Run summary: %0d items sent, %0d results checked, %0d seeding commands,",
                 items_sent, results_seen, seedings);
        $display("  %0d register writes over %0d seed settings, %0d mismatches.",
                 cfg_writes, PHASES, errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Result side: random stall before each item, then check it on acceptance.
    initial begin : result_sink
        int unsigned hold;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            check_result();
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    assign moved = (i_in_valid === 1'b1 && o_in_stall === 1'b0)
                || (o_out_valid === 1'b1 && i_out_stall === 1'b0)
                || (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1);

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || moved) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= STALL_LIMIT) begin
            $display("[%0t] Watchdog: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
